// ----- rtl/smis_pkg.sv -----
// shared types and constants for the sorted multiset insert/search core
package smis_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int VALUE_W          = 32;
  localparam int COUNT_OUT_W      = 7;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic   ins;
    logic   clr;
    value_t key;
  } cell_cmd_t;

endpackage

// ----- rtl/smis_if.sv -----
// request and response channel interfaces
interface smis_in_if;
  logic                 valid;
  logic                 ready;
  smis_pkg::mode_t      mode;
  smis_pkg::value_t     value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface smis_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [smis_pkg::COUNT_OUT_W-1:0]   element_count;
  logic                               rejected;

  modport source (output valid, output found, output element_count, output rejected,
                  input ready);
  modport sink   (input valid, input found, input element_count, input rejected,
                  output ready);
endinterface

// ----- rtl/smis_cell.sv -----
// one storage cell of the sorted chain: compare, hold and shift
module smis_cell (
  input  logic                clk,
  input  logic                rst,
  input  smis_pkg::cell_cmd_t cmd,
  input  logic                prev_cond,
  input  logic                prev_valid,
  input  smis_pkg::value_t    prev_value,
  output logic                cond,
  output logic                valid,
  output smis_pkg::value_t    value,
  output logic                match
);
  import smis_pkg::*;

  // set when the new key belongs at or before this cell
  assign cond  = !valid || (value >= cmd.key);
  assign match = valid && (value == cmd.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && cond) begin
      value <= prev_cond ? prev_value : cmd.key;
    end
  end

endmodule

// ----- rtl/sorted_multiset_insert_search_core.sv -----
// sorted multiset core: chain of compare/shift cells with registered response
// response: registered, valid in the cycle after the request transaction
// throughput: one transaction per cycle while responses are taken; all cells compare and shift in parallel
// a stalled response holds off new requests until it is taken
// reset empties the store and drops any pending response; no clearing pass
module sorted_multiset_insert_search_core #(
  parameter int CAPACITY = smis_pkg::CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  smis_in_if.sink    req,
  smis_out_if.source rsp
);
  import smis_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  cell_cmd_t            cmd;
  logic [CAPACITY-1:0]  cond;
  logic [CAPACITY-1:0]  valid;
  logic [CAPACITY-1:0]  match;
  value_t               value [CAPACITY];
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 accept;
  logic                 full;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(CAPACITY));

  assign cmd.ins = accept && (req.mode == MODE_INSERT) && !full;
  assign cmd.clr = accept && (req.mode == MODE_CLEAR);
  assign cmd.key = req.value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        smis_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmd        (cmd),
          .prev_cond  (1'b0),
          .prev_valid (1'b1),
          .prev_value (req.value),
          .cond       (cond[i]),
          .valid      (valid[i]),
          .value      (value[i]),
          .match      (match[i])
        );
      end else begin : g_body
        smis_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmd        (cmd),
          .prev_cond  (cond[i-1]),
          .prev_valid (valid[i-1]),
          .prev_value (value[i-1]),
          .cond       (cond[i]),
          .valid      (valid[i]),
          .value      (value[i]),
          .match      (match[i])
        );
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (cmd.clr) begin
      count_next = '0;
    end else if (cmd.ins) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.found         <= (req.mode == MODE_SEARCH) && (|match);
      rsp.element_count <= COUNT_OUT_W'(count_next);
      rsp.rejected      <= (req.mode == MODE_INSERT) && full;
    end
  end

endmodule
